@@ hw/rtl/utf16_to_utf8_prefixed_string_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-16LE to UTF-8 converter
// Shared property shapes, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_PREFIXED_STRING_TOP_DEFINES_SVH
`define UTF16_TO_UTF8_PREFIXED_STRING_TOP_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define U16U8PS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define U16U8PS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/u16u8ps_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8ps_pkg
// Types and constants shared by the converter front end, queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u16u8ps_pkg;

    // Widest prefix value before the range check: five bytes of seven bits.
    localparam int PREFIX_BITS      = 35;
    localparam int MAX_PREFIX_BYTES = 5;
    localparam int LENGTH_W         = 29;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_DATA   = 2'd1,
        PH_DRAIN  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_PREFIX_TRUNC = 2'd0,
        ERR_TOO_LARGE    = 2'd1,
        ERR_DATA_TRUNC   = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_END  = 2'd1,
        TAIL_ERR  = 2'd2
    } tail_t;

    // One command per input item that gives any result: an optional code
    // unit to encode, followed by an optional end marker or error.
    typedef struct packed {
        logic                  unit_valid;
        logic [15:0]           unit;
        logic [1:0]            unit_len;
        tail_t                 tail;
        err_t                  err_code;
        logic [LENGTH_W-1:0]   length;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    localparam logic [7:0] UTF8_CONT = 8'h80;
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;

endpackage

@@ hw/rtl/u16u8ps_front.sv @@
// ----------------------------------------------------------------------------
// u16u8ps_front
// Parses the length prefix, pairs data bytes into code units and issues one
// command per input item that causes results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u16u8ps_front #(
    parameter int MAX_LENGTH_BITS = 28
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_data,
    output logic                 push,
    output u16u8ps_pkg::cmd_t    cmd
);

    localparam int MLB = MAX_LENGTH_BITS;
    localparam int CW  = MAX_LENGTH_BITS + 1;

    u16u8ps_pkg::phase_t phase_reg, phase_next;
    logic [MLB-1:0] acc_reg, acc_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic [MLB-1:0] rem_reg, rem_next;
    logic [7:0]     hold_reg, hold_next;
    logic           have_reg, have_next;
    logic [CW-1:0]  count_reg, count_next;

    logic                                 accept;
    logic [u16u8ps_pkg::PREFIX_BITS-1:0] shifted;
    logic [u16u8ps_pkg::PREFIX_BITS-1:0] acc_wide;
    logic                                 too_large;
    logic                                 too_many;
    logic [15:0]                          unit;
    logic [1:0]                           unit_len;
    logic [MLB-1:0]                       rem_dec;
    logic [CW-1:0]                        count_plus;
    logic                                 has_result;

    assign accept = in_valid && in_ready;

    always_comb begin
        case (cnt_reg)
            3'd0:    shifted = u16u8ps_pkg::PREFIX_BITS'(data_byte[6:0]);
            3'd1:    shifted = u16u8ps_pkg::PREFIX_BITS'(data_byte[6:0]) << 7;
            3'd2:    shifted = u16u8ps_pkg::PREFIX_BITS'(data_byte[6:0]) << 14;
            3'd3:    shifted = u16u8ps_pkg::PREFIX_BITS'(data_byte[6:0]) << 21;
            3'd4:    shifted = u16u8ps_pkg::PREFIX_BITS'(data_byte[6:0]) << 28;
            default: shifted = '0;
        endcase
    end

    assign acc_wide   = u16u8ps_pkg::PREFIX_BITS'(acc_reg) | shifted;
    assign too_large  = |acc_wide[u16u8ps_pkg::PREFIX_BITS-1:MLB];
    assign too_many   = (cnt_reg >= 3'(u16u8ps_pkg::MAX_PREFIX_BYTES));
    assign unit       = {data_byte, hold_reg};
    assign unit_len   = (unit[15:7] == '0) ? 2'd1 : ((unit[15:11] == '0) ? 2'd2 : 2'd3);
    assign rem_dec    = rem_reg - {{(MLB-1){1'b0}}, 1'b1};
    assign count_plus = count_reg + CW'(unit_len);

    // Next state.
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        hold_next  = hold_reg;
        have_next  = have_reg;
        count_next = count_reg;
        case (phase_reg)
            u16u8ps_pkg::PH_DRAIN: begin
                if (end_of_data) begin
                    phase_next = u16u8ps_pkg::PH_PREFIX;
                end
            end
            u16u8ps_pkg::PH_PREFIX: begin
                if (too_many || too_large || (data_byte[7] && end_of_data)) begin
                    phase_next = end_of_data ? u16u8ps_pkg::PH_PREFIX : u16u8ps_pkg::PH_DRAIN;
                    acc_next   = '0;
                    cnt_next   = '0;
                end else if (data_byte[7]) begin
                    acc_next = acc_wide[MLB-1:0];
                    cnt_next = cnt_reg + 3'd1;
                end else begin
                    acc_next = '0;
                    cnt_next = '0;
                    if (acc_wide != '0 && !end_of_data) begin
                        phase_next = u16u8ps_pkg::PH_DATA;
                        rem_next   = acc_wide[MLB-1:0];
                        count_next = '0;
                        have_next  = 1'b0;
                        hold_next  = '0;
                    end
                end
            end
            u16u8ps_pkg::PH_DATA: begin
                rem_next = rem_dec;
                if (have_reg) begin
                    have_next  = 1'b0;
                    count_next = count_plus;
                end else begin
                    hold_next = data_byte;
                    have_next = 1'b1;
                end
                if (rem_dec == '0 || end_of_data) begin
                    have_next  = 1'b0;
                    phase_next = u16u8ps_pkg::PH_PREFIX;
                end
            end
            default: begin
                phase_next = u16u8ps_pkg::PH_PREFIX;
            end
        endcase
    end

    // Command for the back end.
    always_comb begin
        cmd            = '0;
        cmd.unit       = unit;
        cmd.unit_len   = unit_len;
        cmd.tail       = u16u8ps_pkg::TAIL_NONE;
        cmd.err_code   = u16u8ps_pkg::ERR_PREFIX_TRUNC;
        case (phase_reg)
            u16u8ps_pkg::PH_PREFIX: begin
                if (too_many || too_large) begin
                    cmd.tail     = u16u8ps_pkg::TAIL_ERR;
                    cmd.err_code = u16u8ps_pkg::ERR_TOO_LARGE;
                end else if (data_byte[7]) begin
                    if (end_of_data) begin
                        cmd.tail     = u16u8ps_pkg::TAIL_ERR;
                        cmd.err_code = u16u8ps_pkg::ERR_PREFIX_TRUNC;
                    end
                end else if (acc_wide == '0) begin
                    cmd.tail = u16u8ps_pkg::TAIL_END;
                end else if (end_of_data) begin
                    cmd.tail     = u16u8ps_pkg::TAIL_ERR;
                    cmd.err_code = u16u8ps_pkg::ERR_DATA_TRUNC;
                end
            end
            u16u8ps_pkg::PH_DATA: begin
                cmd.unit_valid = have_reg;
                if (rem_dec == '0) begin
                    cmd.tail   = u16u8ps_pkg::TAIL_END;
                    cmd.length = u16u8ps_pkg::LENGTH_W'(have_reg ? count_plus : count_reg);
                end else if (end_of_data) begin
                    cmd.tail     = u16u8ps_pkg::TAIL_ERR;
                    cmd.err_code = u16u8ps_pkg::ERR_DATA_TRUNC;
                end
            end
            default: begin
                cmd.tail = u16u8ps_pkg::TAIL_NONE;
            end
        endcase
    end

    assign has_result = cmd.unit_valid || (cmd.tail != u16u8ps_pkg::TAIL_NONE);
    assign push       = accept && has_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= u16u8ps_pkg::PH_PREFIX;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            hold_reg  <= '0;
            have_reg  <= 1'b0;
            count_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            hold_reg  <= hold_next;
            have_reg  <= have_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/u16u8ps_queue.sv @@
// ----------------------------------------------------------------------------
// u16u8ps_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u16u8ps_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  u16u8ps_pkg::cmd_t             push_cmd,
    input  logic                          pop,
    output u16u8ps_pkg::cmd_t             head_cmd,
    output u16u8ps_pkg::queue_status_t    status
);

    u16u8ps_pkg::cmd_t                   entry_reg [u16u8ps_pkg::QUEUE_DEPTH];
    logic [u16u8ps_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [u16u8ps_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [u16u8ps_pkg::QUEUE_CW-1:0]    level_reg, level_next;
    logic                                do_push;
    logic                                do_pop;

    assign status.full  = (level_reg == u16u8ps_pkg::QUEUE_CW'(u16u8ps_pkg::QUEUE_DEPTH));
    assign status.empty = (level_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/u16u8ps_back.sv @@
// ----------------------------------------------------------------------------
// u16u8ps_back
// Takes commands from the queue and delivers their result items one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u16u8ps_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  u16u8ps_pkg::cmd_t                   head_cmd,
    input  u16u8ps_pkg::queue_status_t          q_status,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          result_kind,
    output logic [7:0]                          out_byte,
    output logic [u16u8ps_pkg::LENGTH_W-1:0]    utf8_length,
    output logic [1:0]                          error_code,
    output logic                                last_of_run
);

    u16u8ps_pkg::cmd_t cur_reg;
    logic              cur_valid_reg;
    logic [1:0]        pos_reg;

    logic [2:0]        total;
    logic              in_unit;
    logic              last;
    logic              take;

    function automatic logic [7:0] encode(input logic [15:0] u, input logic [1:0] len,
                                          input logic [1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            2'd1: b = {1'b0, u[6:0]};
            2'd2: b = (pos == 2'd0) ? (u16u8ps_pkg::UTF8_LEAD2 | {3'b000, u[10:6]})
                                    : (u16u8ps_pkg::UTF8_CONT | {2'b00, u[5:0]});
            2'd3: begin
                if (pos == 2'd0) begin
                    b = u16u8ps_pkg::UTF8_LEAD3 | {4'b0000, u[15:12]};
                end else if (pos == 2'd1) begin
                    b = u16u8ps_pkg::UTF8_CONT | {2'b00, u[11:6]};
                end else begin
                    b = u16u8ps_pkg::UTF8_CONT | {2'b00, u[5:0]};
                end
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    assign total   = (cur_reg.unit_valid ? {1'b0, cur_reg.unit_len} : 3'd0)
                   + ((cur_reg.tail != u16u8ps_pkg::TAIL_NONE) ? 3'd1 : 3'd0);
    assign in_unit = cur_reg.unit_valid && (pos_reg < cur_reg.unit_len);
    assign last    = ({1'b0, pos_reg} + 3'd1 == total);
    assign take    = out_valid && out_ready;
    assign pop     = !q_status.empty && (!cur_valid_reg || (take && last));

    assign out_valid   = cur_valid_reg;
    assign last_of_run = last;

    always_comb begin
        result_kind = u16u8ps_pkg::KIND_BYTE;
        out_byte    = '0;
        utf8_length = '0;
        error_code  = '0;
        if (in_unit) begin
            out_byte = encode(cur_reg.unit, cur_reg.unit_len, pos_reg);
        end else if (cur_reg.tail == u16u8ps_pkg::TAIL_END) begin
            result_kind = u16u8ps_pkg::KIND_END;
            utf8_length = cur_reg.length;
        end else begin
            result_kind = u16u8ps_pkg::KIND_ERR;
            error_code  = cur_reg.err_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else if (pop) begin
            cur_valid_reg <= 1'b1;
            pos_reg       <= '0;
        end else if (take) begin
            if (last) begin
                cur_valid_reg <= 1'b0;
                pos_reg       <= '0;
            end else begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head_cmd;
        end
    end

endmodule

@@ hw/rtl/utf16_to_utf8_prefixed_string_top.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_prefixed_string_top
// Length-prefixed UTF-16LE byte stream in, UTF-8 bytes and end markers out.
// ----------------------------------------------------------------------------
// The block accepts one input byte per cycle whenever its four-entry command
// queue has room. Each item that causes results turns into one queued
// command, from which the back end delivers one result item per cycle while
// m_ready is high, so an item gives one to four result items (three bytes
// for a code unit of 0x800 or above, plus an end marker or an error). The
// sustained rate is therefore set by the back end's result output.
`timescale 1ns / 1ps
`include "utf16_to_utf8_prefixed_string_top_defines.svh"

module utf16_to_utf8_prefixed_string_top #(
    parameter int MAX_LENGTH_BITS = 28
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_end_of_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_result_kind,
    output logic [7:0]                          m_out_byte,
    output logic [u16u8ps_pkg::LENGTH_W-1:0]    m_utf8_length,
    output logic [1:0]                          m_error_code,
    output logic                                m_last_of_run
);

    u16u8ps_pkg::cmd_t             push_cmd;
    u16u8ps_pkg::cmd_t             head_cmd;
    u16u8ps_pkg::queue_status_t    q_status;
    logic                          push;
    logic                          pop;

    assign s_ready = !q_status.full;

    u16u8ps_front #(
        .MAX_LENGTH_BITS(MAX_LENGTH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .data_byte   (s_data_byte),
        .end_of_data (s_end_of_data),
        .push        (push),
        .cmd         (push_cmd)
    );

    u16u8ps_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    u16u8ps_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_cmd    (head_cmd),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .result_kind (m_result_kind),
        .out_byte    (m_out_byte),
        .utf8_length (m_utf8_length),
        .error_code  (m_error_code),
        .last_of_run (m_last_of_run)
    );

    // An end marker or an error always closes the run of its item.
    `U16U8PS_ASSERT_SAME(a_tail_is_last, m_valid && m_result_kind != u16u8ps_pkg::KIND_BYTE, m_last_of_run, "end marker or error not last of run")
    // While the queue holds a command, the back end has a valid result in the next cycle.
    `U16U8PS_ASSERT_NEXT(a_queue_drains, !q_status.empty, m_valid, "queued command not picked up")
    // Only UTF-8 byte results carry a byte value.
    `U16U8PS_ASSERT_SAME(a_byte_zero, m_valid && m_result_kind != u16u8ps_pkg::KIND_BYTE, m_out_byte == 8'h00, "nonzero byte on marker or error")

endmodule

@@ dv/tb_utf16_to_utf8_prefixed_string_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_prefixed_string_top
// Streams length-prefixed UTF-16LE buffers into the converter. A behavioral
// model of the decoder predicts every UTF-8 byte, end marker and error, and a
// scoreboard checks each result item in order under random source and sink
// idling, including one long sink stall that backs the block up.
// ----------------------------------------------------------------------------

module tb_utf16_to_utf8_prefixed_string_top;

    localparam int LEN_BITS       = 28;
    localparam int HOLD_CYCLES    = 120;
    localparam int RANDOM_PER_MIX = 56;
    localparam int LEN_W          = u16u8ps_pkg::LENGTH_W;

    typedef struct {
        u16u8ps_pkg::kind_t  kind;
        logic [7:0]          ob;
        logic [LEN_W-1:0]    len;
        logic [1:0]          code;
        logic                last;
    } utf8_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_data_byte;
    logic                s_end_of_data;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_result_kind;
    logic [7:0]          m_out_byte;
    logic [LEN_W-1:0]    m_utf8_length;
    logic [1:0]          m_error_code;
    logic                m_last_of_run;

    // Decoder model state.
    u16u8ps_pkg::phase_t conv_phase;
    logic [27:0]         prefix_value;
    logic [2:0]          prefix_bytes;
    logic [27:0]         data_left;
    logic [7:0]          low_byte;
    logic                low_valid;
    logic [LEN_W-1:0]    utf8_count;

    utf8_result_t        expected_q[$];
    utf8_result_t        run_q[$];
    logic [7:0]          frame_q[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_request;
    int          mismatches;
    int          items_sent;
    int          items_counted;
    int          results_checked;
    int          strings_ended;
    int          errors_flagged;
    int          stalls_seen;

    utf16_to_utf8_prefixed_string_top #(
        .MAX_LENGTH_BITS(LEN_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_end_of_data (s_end_of_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_out_byte    (m_out_byte),
        .m_utf8_length (m_utf8_length),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic void reset_decoder();
        conv_phase   = u16u8ps_pkg::PH_PREFIX;
        prefix_value = '0;
        prefix_bytes = '0;
        data_left    = '0;
        low_byte     = '0;
        low_valid    = 1'b0;
        utf8_count   = '0;
        expected_q.delete();
    endfunction

    function automatic void emit(u16u8ps_pkg::kind_t k, logic [7:0] ob,
                                 logic [LEN_W-1:0] len, logic [1:0] code);
        utf8_result_t r;
        r.kind = k;
        r.ob   = ob;
        r.len  = len;
        r.code = code;
        r.last = 1'b0;
        run_q.push_back(r);
    endfunction

    function automatic void flag_error(u16u8ps_pkg::err_t code, logic eod);
        emit(u16u8ps_pkg::KIND_ERR, 8'h00, '0, code);
        conv_phase   = eod ? u16u8ps_pkg::PH_PREFIX : u16u8ps_pkg::PH_DRAIN;
        prefix_value = '0;
        prefix_bytes = '0;
    endfunction

    // Returns 1 when the item is swallowed while skipping to the end of a buffer.
    function automatic bit decode_byte(logic [7:0] b, logic eod);
        logic [34:0] acc;
        logic [15:0] unit;
        bit          skipped;
        skipped = 1'b0;
        run_q.delete();
        case (conv_phase)
            u16u8ps_pkg::PH_DRAIN: begin
                skipped = 1'b1;
                if (eod) conv_phase = u16u8ps_pkg::PH_PREFIX;
            end
            u16u8ps_pkg::PH_PREFIX: begin
                if (prefix_bytes >= 3'(u16u8ps_pkg::MAX_PREFIX_BYTES)) begin
                    flag_error(u16u8ps_pkg::ERR_TOO_LARGE, eod);
                end else begin
                    acc = {7'b0, prefix_value} | (35'(b[6:0]) << (7 * prefix_bytes));
                    prefix_bytes = prefix_bytes + 3'd1;
                    if (acc[34:LEN_BITS] != '0) begin
                        flag_error(u16u8ps_pkg::ERR_TOO_LARGE, eod);
                    end else if (b[7]) begin
                        if (eod) flag_error(u16u8ps_pkg::ERR_PREFIX_TRUNC, eod);
                        else prefix_value = acc[27:0];
                    end else begin
                        prefix_value = '0;
                        prefix_bytes = '0;
                        if (acc == '0) begin
                            emit(u16u8ps_pkg::KIND_END, 8'h00, '0, 2'b00);
                        end else if (eod) begin
                            flag_error(u16u8ps_pkg::ERR_DATA_TRUNC, eod);
                        end else begin
                            conv_phase = u16u8ps_pkg::PH_DATA;
                            data_left  = acc[27:0];
                            utf8_count = '0;
                            low_valid  = 1'b0;
                            low_byte   = '0;
                        end
                    end
                end
            end
            default: begin
                data_left = data_left - 28'd1;
                if (low_valid) begin
                    unit      = {b, low_byte};
                    low_valid = 1'b0;
                    if (unit < 16'h0080) begin
                        emit(u16u8ps_pkg::KIND_BYTE, unit[7:0], '0, 2'b00);
                    end else if (unit < 16'h0800) begin
                        emit(u16u8ps_pkg::KIND_BYTE,
                             u16u8ps_pkg::UTF8_LEAD2 | {3'b0, unit[10:6]}, '0, 2'b00);
                        emit(u16u8ps_pkg::KIND_BYTE,
                             u16u8ps_pkg::UTF8_CONT | {2'b0, unit[5:0]}, '0, 2'b00);
                    end else begin
                        emit(u16u8ps_pkg::KIND_BYTE,
                             u16u8ps_pkg::UTF8_LEAD3 | {4'b0, unit[15:12]}, '0, 2'b00);
                        emit(u16u8ps_pkg::KIND_BYTE,
                             u16u8ps_pkg::UTF8_CONT | {2'b0, unit[11:6]}, '0, 2'b00);
                        emit(u16u8ps_pkg::KIND_BYTE,
                             u16u8ps_pkg::UTF8_CONT | {2'b0, unit[5:0]}, '0, 2'b00);
                    end
                    utf8_count = utf8_count + LEN_W'(run_q.size());
                end else begin
                    low_byte  = b;
                    low_valid = 1'b1;
                end
                if (data_left == '0) begin
                    emit(u16u8ps_pkg::KIND_END, 8'h00, utf8_count, 2'b00);
                    low_valid  = 1'b0;
                    conv_phase = u16u8ps_pkg::PH_PREFIX;
                end else if (eod) begin
                    low_valid = 1'b0;
                    flag_error(u16u8ps_pkg::ERR_DATA_TRUNC, eod);
                end
            end
        endcase
        if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i]) expected_q.push_back(run_q[i]);
        return skipped;
    endfunction

    // ------------------------------------------------------------------------
    // Source side: called at a falling edge, returns at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eod);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_end_of_data <= eod;
        @(posedge aclk);
        while (!s_ready) begin
            stalls_seen++;
            @(posedge aclk);
        end
        if (!decode_byte(b, eod)) items_counted++;
        items_sent++;
        @(negedge aclk);
    endtask

    // Sends the queued bytes; end_of_data goes on byte eod_at, which ends the frame.
    task automatic send_frame(input int eod_at);
        int  i;
        bit  done;
        done = 1'b0;
        for (i = 0; i < frame_q.size() && !done; i++) begin
            done = (i == eod_at);
            send_byte(frame_q[i], done);
        end
        frame_q.delete();
    endtask

    function automatic void add_prefix(int unsigned value, bit padded);
        int unsigned v;
        logic [7:0]  group;
        v = value;
        do begin
            group = 8'(v & 32'h7F);
            v     = v >> 7;
            if (v != 0 || padded) group = group | 8'h80;
            frame_q.push_back(group);
        end while (v != 0);
        // A redundant zero group keeps the value but lengthens the prefix.
        if (padded) frame_q.push_back(8'h00);
    endfunction

    function automatic void add_unit(logic [15:0] u);
        frame_q.push_back(u[7:0]);
        frame_q.push_back(u[15:8]);
    endfunction

    function automatic logic [15:0] pick_unit();
        case ($urandom_range(4))
            0:       return 16'($urandom_range(16'h007F, 16'h0000));
            1:       return 16'($urandom_range(16'h07FF, 16'h0080));
            2:       return 16'($urandom_range(16'hFFFF, 16'h0800));
            3:       return 16'($urandom_range(16'hDFFF, 16'hD800));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_for_results();
        int guard;
        guard = 0;
        while (expected_q.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Sink side
    // ------------------------------------------------------------------------
    initial begin : sink_driver
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        utf8_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected item: expected none, got kind %0d byte %h len %0d err %0d",
                         $time, m_result_kind, m_out_byte, m_utf8_length, m_error_code);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                compare_field("result_kind", want.kind, m_result_kind);
                compare_field("out_byte", want.ob, m_out_byte);
                compare_field("utf8_length", want.len, m_utf8_length);
                compare_field("error_code", want.code, m_error_code);
                compare_field("last_of_run", want.last, m_last_of_run);
                results_checked++;
                if (want.kind == u16u8ps_pkg::KIND_END) strings_ended++;
                if (want.kind == u16u8ps_pkg::KIND_ERR) errors_flagged++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_and_code_units();
        send_byte(8'h00, 1'b0);
        // Eleven data bytes: five code units across all widths, a lone
        // surrogate, and an odd byte that is dropped. The end marker wins over
        // end_of_data on the final byte.
        send_byte(8'h0B, 1'b0);
        add_unit(16'h007F);
        add_unit(16'h0080);
        add_unit(16'h07FF);
        add_unit(16'hD800);
        add_unit(16'hFFFF);
        frame_q.push_back(8'hA5);
        send_frame(frame_q.size() - 1);
    endtask

    task automatic test_prefix_errors();
        send_byte(8'h81, 1'b1);
        // A fifth group with any nonzero payload pushes the length past the
        // limit; the rest of the buffer is skipped.
        repeat (4) send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h35, 1'b1);
        send_byte(8'h02, 1'b1);
    endtask

    task automatic test_data_truncation();
        send_byte(8'h04, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    task automatic test_sink_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        add_prefix(48, 1'b0);
        repeat (24) add_unit(16'($urandom_range(16'hFFFF, 16'h0800)));
        send_frame(-1);
        s_valid <= 1'b0;
        wait_for_results();
    endtask

    task automatic send_random_string();
        int sel;
        int n_units;
        int n_len;
        bit odd;
        sel = $urandom_range(99);
        if (sel < 70) begin
            n_units = ($urandom_range(19) == 0) ? $urandom_range(70, 64) : $urandom_range(8);
            odd     = ($urandom_range(3) == 0);
            n_len   = 2 * n_units + odd;
            add_prefix(n_len, $urandom_range(6) == 0);
            repeat (n_units) add_unit(pick_unit());
            if (odd) frame_q.push_back(8'($urandom));
            send_frame(($urandom_range(2) == 0) ? frame_q.size() - 1 : -1);
        end else if (sel < 80) begin
            // Buffer ends somewhere inside the prefix or the data.
            n_units = $urandom_range(6, 1);
            add_prefix(2 * n_units, $urandom_range(3) == 0);
            repeat (n_units) add_unit(pick_unit());
            send_frame($urandom_range(frame_q.size() - 2, 0));
        end else if (sel < 85) begin
            repeat ($urandom_range(4, 1)) frame_q.push_back(8'($urandom) | 8'h80);
            send_frame(frame_q.size() - 1);
        end else if (sel < 90) begin
            repeat (4) frame_q.push_back(8'($urandom) | 8'h80);
            if ($urandom_range(1)) begin
                // Six prefix bytes while the value itself stays in range.
                frame_q.push_back(8'h80);
                frame_q.push_back(8'($urandom));
            end else begin
                frame_q.push_back(8'($urandom_range(127, 1)) | {1'($urandom_range(1)), 7'b0});
            end
            if ($urandom_range(2) != 0)
                repeat ($urandom_range(4, 1)) frame_q.push_back(8'($urandom));
            send_frame(frame_q.size() - 1);
        end else begin
            repeat ($urandom_range(6, 1)) frame_q.push_back(8'($urandom));
            send_frame(frame_q.size() - 1);
        end
    endtask

    task automatic test_random_strings(input int unsigned idle_pct, input int unsigned stall_pct);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = items_counted;
        while (items_counted - start < RANDOM_PER_MIX) send_random_string();
        s_valid <= 1'b0;
        wait_for_results();
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data_byte     = 8'h00;
        s_end_of_data   = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_request    = 1'b0;
        mismatches      = 0;
        items_sent      = 0;
        items_counted   = 0;
        results_checked = 0;
        strings_ended   = 0;
        errors_flagged  = 0;
        stalls_seen     = 0;
        reset_decoder();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_and_code_units();
        test_prefix_errors();
        test_data_truncation();
        s_valid <= 1'b0;
        wait_for_results();
        test_sink_hold_off();
        test_random_strings(0, 0);
        test_random_strings(55, 0);
        test_random_strings(0, 55);
        test_random_strings(6, 6);

        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected items never arrived, next expected kind %0d",
                     $time, expected_q.size(), expected_q[0].kind);
            mismatches += expected_q.size();
        end
        $display("Sent %0d bytes (%0d decoded), checked %0d result items.",
                 items_sent, items_counted, results_checked);
        $display("Saw %0d end markers, %0d errors, %0d input stall cycles; %0d mismatches.",
                 strings_ended, errors_flagged, stalls_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
